// ----- design/mars_pkg.sv -----
// shared types, constants and helpers of the reaction step engine
`timescale 1ns / 1ps
package mars_pkg;

   localparam int SPECIES_MAX = 64;
   localparam int RXN_MAX     = 256;
   localparam int SPEC_AW     = $clog2(SPECIES_MAX);
   localparam int RXN_AW      = $clog2(RXN_MAX);
   localparam int CNT_W       = RXN_AW + 1;
   localparam logic [2:0] UPD_LAST = 3'd5;

   typedef enum logic [2:0] {
      OP_LOAD_SPECIES  = 3'd0,
      OP_LOAD_REACTION = 3'd1,
      OP_STEP          = 3'd2,
      OP_READ          = 3'd3,
      OP_RESTART       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_TIME_STEP      = 2'd0,
      CSR_SPECIES_COUNT  = 2'd1,
      CSR_REACTION_COUNT = 2'd2,
      CSR_STEP_LIMIT     = 2'd3
   } csr_type;

   typedef enum logic [5:0] {
      S_IDLE, S_DISP, S_LD_SP, S_LD_RX, S_RD_ADDR, S_RD_DATA,
      S_RS_INIT, S_RS_CHK, S_RS_CP,
      S_SP_INIT, S_SP_CHK, S_SP_RD, S_SP_ADD, S_SP_M1, S_SP_M2, S_SP_M3, S_SP_M4,
      S_SP_WR, S_SP_END,
      S_RX_CHK, S_RX_RD, S_RX_RB, S_RX_RP, S_RX_LP,
      S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7,
      S_B1, S_B2, S_B3, S_B4,
      S_UP_RD, S_UP_WR, S_RX_NEXT, S_RX_END,
      S_PK_CHK, S_PK_CMP, S_FIN
   } state_type;

   typedef enum logic [5:0] {
      C_IDLE, C_NOP, C_LD_SP, C_LD_RX, C_RD_ADDR, C_RD_DATA,
      C_RS_INIT, C_RS_CHK, C_RS_CP,
      C_SP_INIT, C_SP_CHK, C_SP_RD, C_SP_ADD, C_SP_M1, C_SP_WR, C_SP_END,
      C_M_LO_DT, C_M_HI, C_M_SUM, C_M_LO_FWD,
      C_RX_CHK, C_RX_RD, C_RX_RB, C_RX_RP, C_RX_LP, C_RX_FCAP, C_RX_BCAP,
      C_UP_RD, C_UP_WR, C_RX_NEXT, C_RX_END,
      C_PK_CHK, C_PK_CMP, C_FIN
   } cmd_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  slot;
      logic [31:0] start_level;
      logic [31:0] birth_rate;
      logic [31:0] decay_rate;
      logic        is_source;
      logic [5:0]  first_reactant;
      logic [5:0]  second_reactant;
      logic [5:0]  product_slot;
      logic [31:0] forward_rate;
      logic [31:0] backward_rate;
   } req_type;

   typedef struct packed {
      logic        finished;
      logic        saturated;
      logic [5:0]  peak_species;
      logic [31:0] peak_level;
      logic [31:0] ticks_done;
      logic [31:0] level_read;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic   finished;
      logic   cnt_lt_ns;
      logic   cnt_lt_nr;
      logic   cnt_lt_max;
      logic   upd_last;
      logic   tick_sat;
      logic   out_free;
   } status_type;

   // {overflow, saturated sum}
   function automatic logic [32:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? {1'b1, 32'hFFFF_FFFF} : s;
   endfunction

   function automatic logic [31:0] sub_clamp(input logic [31:0] v, input logic [47:0] amt);
      return (amt >= {16'b0, v}) ? 32'd0 : (v - amt[31:0]);
   endfunction

endpackage

// ----- design/mass_action_reaction_step.sv -----
// one item at a time: a new request is taken only in idle, once the last one is through
// restart copies all 64 start levels from the start table into the species level table
// the schedule is set by the species level table, with one read and one write port, and
// by the one shared 32x32 multiplier
// a finished result waits in the output register while the next item is taken
// reset is synchronous: CSRs return to their defaults, counters, peak and flags clear, the
// data registers are not reset, species and reaction tables hold nothing defined until loaded
`timescale 1ns / 1ps
module mass_action_reaction_step (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // slot, start_level, birth_rate, decay_rate, is_source, first_reactant,
   // second_reactant, product_slot, forward_rate, backward_rate
   input  logic [191:0]  req_tdata,
   // operation
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // level_read, ticks_done, peak_level, peak_species, saturated, finished
   output logic [103:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata
);
   import mars_pkg::*;

   req_type    req;
   rsp_type    rsp;
   status_type status;
   cmd_type    cmd;

   assign req = '{op: op_type'(req_tuser),
                  slot: req_tdata[7:0],
                  start_level: req_tdata[39:8],
                  birth_rate: req_tdata[71:40],
                  decay_rate: req_tdata[103:72],
                  is_source: req_tdata[104],
                  first_reactant: req_tdata[110:105],
                  second_reactant: req_tdata[116:111],
                  product_slot: req_tdata[122:117],
                  forward_rate: req_tdata[154:123],
                  backward_rate: req_tdata[186:155]};

   assign rsp_tdata = {rsp.finished, rsp.saturated, rsp.peak_species,
                       rsp.peak_level, rsp.ticks_done, rsp.level_read};

   mars_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .status(status),
      .req_tready(req_tready), .cmd(cmd));

   mars_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_accept(req_tvalid && req_tready), .req(req),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp(rsp), .status(status));
endmodule

// ----- design/mars_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module mars_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/mars_datapath.sv -----
// tables, shared multiplier, counters and result register
`timescale 1ns / 1ps
module mars_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  mars_pkg::cmd_type        cmd,
   input  logic                     req_accept,
   input  mars_pkg::req_type        req,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output mars_pkg::rsp_type        rsp,
   output mars_pkg::status_type     status
);
   import mars_pkg::*;

   typedef struct packed {
      logic        source;
      logic [31:0] decay;
      logic [31:0] birth;
   } param_type;

   typedef struct packed {
      logic [31:0] backward;
      logic [31:0] forward;
      logic [5:0]  product;
      logic [5:0]  second;
      logic [5:0]  first;
   } rxn_type;

   logic [31:0] dt_ff, limit_ff;
   logic [6:0]  scount_ff;
   logic [8:0]  rcount_ff;
   logic [31:0] tick_ff, tick_in, peak_ff, peak_in;
   logic [5:0]  pidx_ff, pidx_in;
   logic        ovf_ff, ovf_in, tsat_ff, tsat_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]  upd_ff, upd_in;
   req_type     req_ff;
   logic [31:0] lv_ff, lv_in, la_ff, la_in, lb_ff, lb_in, lp_ff, lp_in;
   logic [31:0] decay_ff, decay_in, y_ff, y_in, fwd_ff, fwd_in, back_ff, back_in;
   logic        src_ff, src_in;
   logic [63:0] prod_ff, prod_in, x_ff, x_in, acc_ff, acc_in;
   rxn_type     rx_ff, rx_in;
   logic [31:0] lread_ff, lread_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   logic                lv_we, st_we, pa_we, rx_we;
   logic [SPEC_AW-1:0]  lv_waddr, lv_raddr;
   logic [31:0]         lv_wdata, lv_rdata, st_rdata;
   param_type           pa_wdata, pa_rdata;
   rxn_type             rx_wdata, rx_rdata;
   logic [RXN_AW-1:0]   rx_raddr;

   logic [CNT_W-1:0] ns, nr;
   logic             slot_ok, fin_now, out_free;
   logic [5:0]       tgt;
   logic [31:0]      amt, cap;
   logic [32:0]      add_r;

   mars_ram #(.WIDTH(32), .DEPTH(SPECIES_MAX)) u_level (
      .clock(clock), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
      .raddr(lv_raddr), .rdata(lv_rdata));
   mars_ram #(.WIDTH(32), .DEPTH(SPECIES_MAX)) u_start (
      .clock(clock), .we(st_we), .waddr(req_ff.slot[SPEC_AW-1:0]),
      .wdata(req_ff.start_level), .raddr(cnt_ff[SPEC_AW-1:0]), .rdata(st_rdata));
   mars_ram #(.WIDTH($bits(param_type)), .DEPTH(SPECIES_MAX)) u_param (
      .clock(clock), .we(pa_we), .waddr(req_ff.slot[SPEC_AW-1:0]),
      .wdata(pa_wdata), .raddr(cnt_ff[SPEC_AW-1:0]), .rdata(pa_rdata));
   mars_ram #(.WIDTH($bits(rxn_type)), .DEPTH(RXN_MAX)) u_rxn (
      .clock(clock), .we(rx_we), .waddr(req_ff.slot[RXN_AW-1:0]),
      .wdata(rx_wdata), .raddr(rx_raddr), .rdata(rx_rdata));

   assign ns = ({2'b0, scount_ff} > CNT_W'(SPECIES_MAX)) ? CNT_W'(SPECIES_MAX)
                                                        : {2'b0, scount_ff};
   assign nr = (rcount_ff > CNT_W'(RXN_MAX)) ? CNT_W'(RXN_MAX) : rcount_ff;
   assign slot_ok  = {1'b0, req_ff.slot} < 9'(SPECIES_MAX);
   assign fin_now  = (tick_ff >= limit_ff) || ovf_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign pa_wdata = '{source: req_ff.is_source, decay: req_ff.decay_rate,
                       birth: req_ff.birth_rate};
   assign rx_wdata = '{backward: req_ff.backward_rate, forward: req_ff.forward_rate,
                       product: req_ff.product_slot, second: req_ff.second_reactant,
                       first: req_ff.first_reactant};

   // update order: a, b, p gain, then a, b, p lose
   always_comb begin
      unique case (upd_ff)
         3'd0, 3'd3: tgt = rx_ff.first;
         3'd1, 3'd4: tgt = rx_ff.second;
         default:    tgt = rx_ff.product;
      endcase
      unique case (upd_ff)
         3'd2, 3'd3, 3'd4: amt = fwd_ff;
         default:          amt = back_ff;
      endcase
   end

   assign cap = (la_ff < lb_ff) ? la_ff : lb_ff;

   always_comb begin
      unique case (cmd)
         C_SP_RD:    begin mul_a = pa_rdata.birth;  mul_b = dt_ff;            end
         C_SP_M1:    begin mul_a = lv_ff;           mul_b = decay_ff;         end
         C_M_LO_DT:  begin mul_a = prod_ff[31:0];   mul_b = dt_ff;            end
         C_M_HI:     begin mul_a = x_ff[63:32];     mul_b = y_ff;             end
         C_RX_LP:    begin mul_a = la_ff;           mul_b = lb_ff;            end
         C_M_LO_FWD: begin mul_a = acc_ff[31:0];    mul_b = rx_ff.forward;    end
         C_RX_FCAP:  begin mul_a = lp_ff;           mul_b = rx_ff.backward;   end
         default:    begin mul_a = '0;              mul_b = '0;               end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      tick_in = tick_ff;  peak_in = peak_ff;  pidx_in = pidx_ff;
      ovf_in = ovf_ff;    tsat_in = tsat_ff;  cnt_in = cnt_ff;   upd_in = upd_ff;
      lv_in = lv_ff;  la_in = la_ff;  lb_in = lb_ff;  lp_in = lp_ff;
      decay_in = decay_ff;  y_in = y_ff;  fwd_in = fwd_ff;  back_in = back_ff;
      src_in = src_ff;  prod_in = prod_ff;  x_in = x_ff;  acc_in = acc_ff;
      rx_in = rx_ff;  lread_in = lread_ff;
      lv_we = 1'b0;  st_we = 1'b0;  pa_we = 1'b0;  rx_we = 1'b0;
      lv_waddr = cnt_ff[SPEC_AW-1:0];  lv_wdata = lv_ff;
      lv_raddr = cnt_ff[SPEC_AW-1:0];
      rx_raddr = cnt_ff[RXN_AW-1:0];
      add_r = '0;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (cmd)
         C_IDLE: begin
            lread_in = '0;
         end
         C_LD_SP: begin
            if (slot_ok) begin
               lv_we = 1'b1;  st_we = 1'b1;  pa_we = 1'b1;
               lv_waddr = req_ff.slot[SPEC_AW-1:0];
               lv_wdata = req_ff.start_level;
            end
         end
         C_LD_RX: rx_we = 1'b1;
         C_RD_ADDR: lv_raddr = req_ff.slot[SPEC_AW-1:0];
         C_RD_DATA: lread_in = slot_ok ? lv_rdata : 32'd0;
         C_RS_INIT: begin
            cnt_in = '0;  tick_in = '0;  peak_in = '0;  pidx_in = '0;  ovf_in = 1'b0;
         end
         C_RS_CP: begin
            lv_we = 1'b1;  lv_wdata = st_rdata;  cnt_in = cnt_ff + 1'b1;
         end
         C_SP_INIT: begin
            cnt_in = '0;  tsat_in = 1'b0;
         end
         C_SP_RD: begin
            lv_in = lv_rdata;  decay_in = pa_rdata.decay;  src_in = pa_rdata.source;
            prod_in = mul_p;
         end
         C_SP_ADD: begin
            if (src_ff) begin
               add_r = sat_add(lv_ff, prod_ff[63:32]);
               lv_in = add_r[31:0];
               if (add_r[32]) begin
                  ovf_in = 1'b1;  tsat_in = 1'b1;
               end
            end
         end
         C_SP_M1: prod_in = mul_p;
         C_M_LO_DT: begin
            x_in = prod_ff;  prod_in = mul_p;  y_in = dt_ff;
         end
         C_M_LO_FWD: begin
            x_in = acc_ff;  prod_in = mul_p;  y_in = rx_ff.forward;
         end
         C_M_HI: begin
            acc_in = {32'b0, prod_ff[63:32]};  prod_in = mul_p;
         end
         C_M_SUM: acc_in = prod_ff + acc_ff;
         C_SP_WR: begin
            lv_we = 1'b1;  lv_wdata = sub_clamp(lv_ff, acc_ff[63:16]);
            cnt_in = cnt_ff + 1'b1;
         end
         C_SP_END: cnt_in = '0;
         C_RX_CHK: upd_in = '0;
         C_RX_RD: begin
            rx_in = rx_rdata;  lv_raddr = rx_rdata.first;
         end
         C_RX_RB: begin
            la_in = lv_rdata;  lv_raddr = rx_ff.second;
         end
         C_RX_RP: begin
            lb_in = lv_rdata;  lv_raddr = rx_ff.product;
         end
         C_RX_LP: begin
            lp_in = lv_rdata;  prod_in = mul_p;
         end
         C_RX_FCAP: begin
            fwd_in = (acc_ff > {32'b0, cap}) ? cap : acc_ff[31:0];
            prod_in = mul_p;
         end
         C_RX_BCAP: begin
            back_in = (acc_ff[63:16] > {16'b0, lp_ff}) ? lp_ff : acc_ff[47:16];
         end
         C_UP_RD: lv_raddr = tgt;
         C_UP_WR: begin
            lv_we = 1'b1;  lv_waddr = tgt;
            if (upd_ff < 3'd3) begin
               add_r = sat_add(lv_rdata, amt);
               lv_wdata = add_r[31:0];
               if (add_r[32]) begin
                  ovf_in = 1'b1;  tsat_in = 1'b1;
               end
            end else begin
               lv_wdata = sub_clamp(lv_rdata, {16'b0, amt});
            end
            upd_in = upd_ff + 1'b1;
         end
         C_RX_NEXT: cnt_in = cnt_ff + 1'b1;
         C_RX_END: begin
            cnt_in = '0;  tick_in = tick_ff + 1'b1;
         end
         C_PK_CMP: begin
            // strictly greater keeps the first species on ties
            if (lv_rdata > peak_ff) begin
               peak_in = lv_rdata;  pidx_in = cnt_ff[5:0];
            end
            cnt_in = cnt_ff + 1'b1;
         end
         C_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{finished: fin_now, saturated: ovf_ff, peak_species: pidx_ff,
                          peak_level: peak_ff, ticks_done: tick_ff, level_read: lread_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= 32'd4294967;  scount_ff <= '0;  rcount_ff <= '0;  limit_ff <= 32'd1000;
         tick_ff <= '0;  peak_ff <= '0;  pidx_ff <= '0;  ovf_ff <= 1'b0;  tsat_ff <= 1'b0;
         cnt_ff <= '0;  upd_ff <= '0;  rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_type'(csr_index))
               CSR_TIME_STEP:      dt_ff <= csr_wdata;
               CSR_SPECIES_COUNT:  scount_ff <= csr_wdata[6:0];
               CSR_REACTION_COUNT: rcount_ff <= csr_wdata[8:0];
               CSR_STEP_LIMIT:     limit_ff <= csr_wdata;
            endcase
         end
         tick_ff <= tick_in;  peak_ff <= peak_in;  pidx_ff <= pidx_in;
         ovf_ff <= ovf_in;  tsat_ff <= tsat_in;  cnt_ff <= cnt_in;  upd_ff <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req;
      end
      lv_ff <= lv_in;  la_ff <= la_in;  lb_ff <= lb_in;  lp_ff <= lp_in;
      decay_ff <= decay_in;  y_ff <= y_in;  fwd_ff <= fwd_in;  back_ff <= back_in;
      src_ff <= src_in;  prod_ff <= prod_in;  x_ff <= x_in;  acc_ff <= acc_in;
      rx_ff <= rx_in;  lread_ff <= lread_in;  rsp_ff <= rsp_in;
   end

   assign status = '{op: req_ff.op, finished: fin_now,
                     cnt_lt_ns: cnt_ff < ns, cnt_lt_nr: cnt_ff < nr,
                     cnt_lt_max: cnt_ff < CNT_W'(SPECIES_MAX),
                     upd_last: upd_ff == UPD_LAST, tick_sat: tsat_ff, out_free: out_free};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp = rsp_ff;
endmodule

// ----- design/mars_ctrl.sv -----
// sequencer that walks species, reactions and the peak scan
`timescale 1ns / 1ps
module mars_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  mars_pkg::status_type status,
   output logic                 req_tready,
   output mars_pkg::cmd_type    cmd
);
   import mars_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_tvalid) state_in = S_DISP;
         S_DISP: begin
            unique case (status.op)
               OP_LOAD_SPECIES:  state_in = S_LD_SP;
               OP_LOAD_REACTION: state_in = S_LD_RX;
               OP_STEP:          state_in = status.finished ? S_FIN : S_SP_INIT;
               OP_READ:          state_in = S_RD_ADDR;
               OP_RESTART:       state_in = S_RS_INIT;
               default:          state_in = S_FIN;
            endcase
         end
         S_LD_SP, S_LD_RX, S_RD_DATA: state_in = S_FIN;
         S_RD_ADDR: state_in = S_RD_DATA;
         S_RS_INIT: state_in = S_RS_CHK;
         S_RS_CHK:  state_in = status.cnt_lt_max ? S_RS_CP : S_FIN;
         S_RS_CP:   state_in = S_RS_CHK;
         S_SP_INIT: state_in = S_SP_CHK;
         S_SP_CHK:  state_in = status.cnt_lt_ns ? S_SP_RD : S_SP_END;
         S_SP_RD:   state_in = S_SP_ADD;
         S_SP_ADD:  state_in = S_SP_M1;
         S_SP_M1:   state_in = S_SP_M2;
         S_SP_M2:   state_in = S_SP_M3;
         S_SP_M3:   state_in = S_SP_M4;
         S_SP_M4:   state_in = S_SP_WR;
         S_SP_WR:   state_in = S_SP_CHK;
         S_SP_END:  state_in = S_RX_CHK;
         S_RX_CHK:  state_in = status.cnt_lt_nr ? S_RX_RD : S_RX_END;
         S_RX_RD:   state_in = S_RX_RB;
         S_RX_RB:   state_in = S_RX_RP;
         S_RX_RP:   state_in = S_RX_LP;
         S_RX_LP:   state_in = S_F1;
         S_F1:      state_in = S_F2;
         S_F2:      state_in = S_F3;
         S_F3:      state_in = S_F4;
         S_F4:      state_in = S_F5;
         S_F5:      state_in = S_F6;
         S_F6:      state_in = S_F7;
         S_F7:      state_in = S_B1;
         S_B1:      state_in = S_B2;
         S_B2:      state_in = S_B3;
         S_B3:      state_in = S_B4;
         S_B4:      state_in = S_UP_RD;
         S_UP_RD:   state_in = S_UP_WR;
         S_UP_WR:   state_in = status.upd_last ? S_RX_NEXT : S_UP_RD;
         S_RX_NEXT: state_in = S_RX_CHK;
         S_RX_END:  state_in = status.tick_sat ? S_FIN : S_PK_CHK;
         S_PK_CHK:  state_in = status.cnt_lt_ns ? S_PK_CMP : S_FIN;
         S_PK_CMP:  state_in = S_PK_CHK;
         S_FIN:     if (status.out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE:    cmd = C_IDLE;
         S_LD_SP:   cmd = C_LD_SP;
         S_LD_RX:   cmd = C_LD_RX;
         S_RD_ADDR: cmd = C_RD_ADDR;
         S_RD_DATA: cmd = C_RD_DATA;
         S_RS_INIT: cmd = C_RS_INIT;
         S_RS_CHK:  cmd = C_RS_CHK;
         S_RS_CP:   cmd = C_RS_CP;
         S_SP_INIT: cmd = C_SP_INIT;
         S_SP_CHK:  cmd = C_SP_CHK;
         S_SP_RD:   cmd = C_SP_RD;
         S_SP_ADD:  cmd = C_SP_ADD;
         S_SP_M1:   cmd = C_SP_M1;
         S_SP_M2, S_F1, S_B1: cmd = C_M_LO_DT;
         S_SP_M3, S_F2, S_F5, S_B2: cmd = C_M_HI;
         S_SP_M4, S_F3, S_F6, S_B3: cmd = C_M_SUM;
         S_F4:      cmd = C_M_LO_FWD;
         S_SP_WR:   cmd = C_SP_WR;
         S_SP_END:  cmd = C_SP_END;
         S_RX_CHK:  cmd = C_RX_CHK;
         S_RX_RD:   cmd = C_RX_RD;
         S_RX_RB:   cmd = C_RX_RB;
         S_RX_RP:   cmd = C_RX_RP;
         S_RX_LP:   cmd = C_RX_LP;
         S_F7:      cmd = C_RX_FCAP;
         S_B4:      cmd = C_RX_BCAP;
         S_UP_RD:   cmd = C_UP_RD;
         S_UP_WR:   cmd = C_UP_WR;
         S_RX_NEXT: cmd = C_RX_NEXT;
         S_RX_END:  cmd = C_RX_END;
         S_PK_CHK:  cmd = C_PK_CHK;
         S_PK_CMP:  cmd = C_PK_CMP;
         S_FIN:     cmd = C_FIN;
         default:   cmd = C_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
